// ===== rtl/tdp_pkg.sv =====
// shared types and result codes for the trial division primality block
package tdp_pkg;

  typedef logic [1:0] class_t;

  localparam class_t CLASS_PRIME     = 2'd0;
  localparam class_t CLASS_COMPOSITE = 2'd1;
  localparam class_t CLASS_NEITHER   = 2'd2;

endpackage

// ===== rtl/tdp_divider.sv =====
// bit-serial restoring divider giving quotient and remainder, one bit a cycle
module tdp_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] dvd;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] dvd_next;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dvd[WIDTH-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    dvd_next = {dvd[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end else if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= rem_next;
      dvd <= dvd_next;
    end else if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

// ===== rtl/trial_division_primality.sv =====
// top level of the trial division primality classifier
//
// Takes one signed VALUE_WIDTH-bit integer per item and returns one 2-bit
// class: 0 prime, 1 composite, 2 neither (magnitude 0 or 1). Only the
// magnitude counts, and the most negative value is read as 2^(VALUE_WIDTH-1).
// Magnitudes below 3 and even magnitudes are settled in the check state.
// An odd magnitude goes through a single bit-serial divider that is reused
// for the divisors 3, 5, 7, ...; each divisor passes through the restart in
// the check state, the divide steps, and the done step in which the
// decision is taken.
// One division yields both the quotient, against which the divisor is
// compared for the square-root bound, and the remainder, tested for zero.
// A prime magnitude m is tried against each odd divisor up to about sqrt(m).
// value_stall stays high from acceptance until the result has been placed
// in the output register, so one item is worked on at a time; the output
// register lets the next item be taken while the previous result waits
// behind result_stall.
module trial_division_primality #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   value_valid,
  output logic                   value_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   result_valid,
  input  logic                   result_stall,
  output tdp_pkg::class_t        number_class
);

  import tdp_pkg::*;

  localparam int W = VALUE_WIDTH;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]   state;
  logic [W-1:0] mag;      // magnitude under test
  logic [W-1:0] dvsr;     // current odd trial divisor
  class_t       cls;      // verdict waiting to go out
  logic [W-1:0] mag_in;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         in_take;
  logic         out_free;

  // magnitude of the incoming item; the most negative value wraps onto itself
  assign mag_in = value[W-1] ? (~value + W'(1)) : value;

  assign value_stall = (state != S_IDLE);
  assign in_take     = value_valid && !value_stall;
  assign out_free    = !result_valid || !result_stall;

  // the divider is only kicked off from the check state, once the easy cases
  // have been ruled out
  assign div_start = (state == S_CHECK) && (mag > W'(2)) && mag[0];

  tdp_divider #(
    .WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (dvsr),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      // a new verdict replaces the one leaving, otherwise the register empties
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // zero, one, two and even magnitudes need no division
          if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // past the square root, or a divisor found: verdict is in
            if ((dvsr > div_quo) || (div_rem == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      mag  <= mag_in;
      dvsr <= W'(3);
    end
    if (state == S_CHECK) begin
      if (mag < W'(2)) begin
        cls <= CLASS_NEITHER;
      end else if (mag == W'(2)) begin
        cls <= CLASS_PRIME;
      end else if (!mag[0]) begin
        cls <= CLASS_COMPOSITE;
      end
    end
    if ((state == S_DIV) && div_done) begin
      if (dvsr > div_quo) begin
        cls <= CLASS_PRIME;
      end else if (div_rem == '0) begin
        cls <= CLASS_COMPOSITE;
      end else begin
        dvsr <= dvsr + W'(2);
      end
    end
    if ((state == S_DONE) && out_free) begin
      number_class <= cls;
    end
  end

endmodule
